/* design/rbca_pkg.sv */
`timescale 1ns / 1ps

package rbca_pkg;

    localparam int SEQ_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 13;

    // Distance bit that separates "ahead of window" from "old"
    localparam int HALF_BIT = SEQ_W - 1;

    // Item kinds
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_FIN  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SEQ_W-1:0]    seq_num;
        logic [HANDLE_W-1:0] payload_handle;
        logic [LEN_W-1:0]    payload_length;
    } t_in_item;

    typedef struct packed {
        logic                deliver_valid;
        logic [SEQ_W-1:0]    deliver_seq;
        logic [HANDLE_W-1:0] deliver_handle;
        logic [LEN_W-1:0]    deliver_length;
        logic                ack_valid;
        logic [SEQ_W-1:0]    ack_num;
        logic [SEQ_W-1:0]    echo_seq;
        logic                fin_ack;
        logic                dropped;
        logic                last;
    } t_out_item;

endpackage

/* design/reorder_buffer_cumulative_ack_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in  (rbca_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready  o_out (rbca_pkg::t_out_item)
//
// Steps: FIN, window, ahead and old packets pass accept, classify and present.
//   An in-order packet passes accept, classify, advance, present, then load,
//   advance, present per drained successor; classify and advance share the one adder.
// Reset: synchronous, active low; expected number 1, window empty.
// Stalls: a result is held in the output register until taken; no new
//   transaction is accepted until the last result of the current one is taken.
module reorder_buffer_cumulative_ack_core #(
    parameter int WINDOW_SLOTS = 16,
    parameter int MAX_PAYLOAD  = 5000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rbca_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rbca_pkg::t_out_item o_out
);

    localparam int HW  = $clog2(WINDOW_SLOTS);
    localparam int CW  = $clog2(WINDOW_SLOTS + 1);
    localparam int SW  = rbca_pkg::SEQ_W;
    localparam int HDW = rbca_pkg::HANDLE_W;
    localparam int LW  = rbca_pkg::LEN_W;
    localparam int RW  = HDW + LW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_ADV,
        S_OUT,
        S_LOAD
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [SW-1:0]       r_seq;
    logic [HDW-1:0]      r_handle;
    logic [LW-1:0]       r_len;
    logic [SW-1:0]       r_exp;
    logic [HW-1:0]       r_head;
    logic [WINDOW_SLOTS-1:0] r_slot_valid;
    logic [CW-1:0]       r_cnt;
    logic                r_more;
    logic [SW-1:0]       r_cur_seq;
    logic [HDW-1:0]      r_cur_handle;
    logic [LW-1:0]       r_cur_len;
    logic                r_out_valid;
    rbca_pkg::t_out_item r_out;
    rbca_pkg::t_out_item n_out;

    logic                w_alu_sub;
    logic [SW-1:0]       w_alu_a;
    logic [SW-1:0]       w_alu_b;
    logic [SW-1:0]       w_alu_y;
    logic                w_in_order;
    logic                w_in_window;
    logic [HW:0]         w_widx_sum;
    logic [HW-1:0]       w_widx;
    logic [HW-1:0]       w_head_inc;
    logic                w_more;
    logic                w_ram_we;
    logic [RW-1:0]       w_ram_rdata;
    logic [LW-1:0]       w_len_sat;

    // Shared adder: distance seq - expected while classifying, expected + 1
    // while advancing the window.
    assign w_alu_sub = (r_state != S_ADV);
    assign w_alu_a   = (r_state == S_ADV) ? r_exp : r_seq;
    assign w_alu_b   = (r_state == S_ADV) ? SW'(1) : r_exp;

    rbca_seq_alu u_alu (
        .i_sub (w_alu_sub),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_y   (w_alu_y)
    );

    // Classify the distance
    assign w_in_order  = (w_alu_y == '0);
    assign w_in_window = (w_alu_y < SW'(WINDOW_SLOTS));

    // Slot for a window packet: head + distance, wrapped once
    assign w_widx_sum = {1'b0, r_head} + {1'b0, w_alu_y[HW-1:0]};
    assign w_widx     = (w_widx_sum >= (HW+1)'(WINDOW_SLOTS))
                        ? HW'(w_widx_sum - (HW+1)'(WINDOW_SLOTS))
                        : w_widx_sum[HW-1:0];

    assign w_head_inc = (r_head == HW'(WINDOW_SLOTS - 1)) ? '0 : r_head + HW'(1);
    assign w_more     = r_slot_valid[w_head_inc] &&
                        ((r_cnt + CW'(1)) < CW'(WINDOW_SLOTS));

    assign w_ram_we = (r_state == S_CLASS) && (r_op == rbca_pkg::OP_DATA) &&
                      !w_in_order && w_in_window;

    // Saturate oversize lengths on the way in
    assign w_len_sat = (17'(i_in.payload_length) > 17'(MAX_PAYLOAD))
                       ? LW'(MAX_PAYLOAD) : i_in.payload_length;

    // Buffered handle and length; read port always follows the head
    rbca_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_widx),
        .i_wdata ({r_handle, r_len}),
        .i_raddr (r_head),
        .o_rdata (w_ram_rdata)
    );

    // Result word for the classify and advance steps
    always_comb begin
        n_out = '0;
        case (r_state)
            S_CLASS: begin
                if (r_op == rbca_pkg::OP_FIN) begin
                    n_out.fin_ack = 1'b1;
                    n_out.last    = 1'b1;
                end else if (!w_in_order) begin
                    n_out.ack_valid = 1'b1;
                    n_out.ack_num   = r_exp;
                    n_out.echo_seq  = r_seq;
                    n_out.dropped   = !w_in_window && !w_alu_y[rbca_pkg::HALF_BIT];
                    n_out.last      = 1'b1;
                end
            end
            S_ADV: begin
                n_out.deliver_valid  = 1'b1;
                n_out.deliver_seq    = r_cur_seq;
                n_out.deliver_handle = r_cur_handle;
                n_out.deliver_length = r_cur_len;
                // Only the final release of the run carries the acknowledgement
                if (!w_more) begin
                    n_out.ack_valid = 1'b1;
                    n_out.ack_num   = w_alu_y;
                    n_out.echo_seq  = r_seq;
                    n_out.last      = 1'b1;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_exp        <= SW'(1);
            r_head       <= '0;
            r_slot_valid <= '0;
            r_cnt        <= '0;
            r_more       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // Latch the arriving transaction
                    if (i_in_valid) begin
                        r_op     <= i_in.op;
                        r_seq    <= i_in.seq_num;
                        r_handle <= i_in.payload_handle;
                        r_len    <= w_len_sat;
                        r_state  <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_out   <= n_out;
                    r_more  <= 1'b0;
                    r_cnt   <= '0;
                    if (r_op == rbca_pkg::OP_FIN) begin
                        r_out_valid   <= 1'b1;
                        r_state       <= S_OUT;
                    end else if (w_in_order) begin
                        // Release this packet first; drain follows
                        r_slot_valid[r_head] <= 1'b0;
                        r_cur_seq    <= r_seq;
                        r_cur_handle <= r_handle;
                        r_cur_len    <= r_len;
                        r_state      <= S_ADV;
                    end else begin
                        if (w_in_window) begin
                            r_slot_valid[w_widx] <= 1'b1;
                        end
                        r_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end
                end
                S_ADV: begin
                    // Advance expected number and head, present the release
                    r_exp  <= w_alu_y;
                    r_head <= w_head_inc;
                    r_more <= w_more;
                    r_out  <= n_out;
                    if (w_more) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    // Hold the result until taken
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_more ? S_LOAD : S_IDLE;
                    end
                end
                S_LOAD: begin
                    // Pick up the buffered successor at the new head
                    r_cur_seq            <= r_exp;
                    r_cur_handle         <= w_ram_rdata[RW-1:LW];
                    r_cur_len            <= w_ram_rdata[LW-1:0];
                    r_slot_valid[r_head] <= 1'b0;
                    r_state              <= S_ADV;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after accepting a transaction");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_slot_valid[r_head])
        else $error("slot at head still occupied while idle");

    a_drain_acks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.deliver_valid) |-> (o_out.last == o_out.ack_valid))
        else $error("release carries acknowledgement on the wrong result");

    a_exp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |=> (r_exp == $past(r_exp) + SW'(1)))
        else $error("expected number did not advance by one");
`endif

endmodule

/* design/rbca_ram.sv */
`timescale 1ns / 1ps

module rbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rbca_seq_alu.sv */
`timescale 1ns / 1ps

// Sequence-space adder: a + b or a - b, modulo 2^SEQ_W.
module rbca_seq_alu (
    input  logic                      i_sub,
    input  logic [rbca_pkg::SEQ_W-1:0] i_a,
    input  logic [rbca_pkg::SEQ_W-1:0] i_b,
    output logic [rbca_pkg::SEQ_W-1:0] o_y
);

    logic [rbca_pkg::SEQ_W-1:0] w_b;

    assign w_b = i_sub ? ~i_b : i_b;
    assign o_y = i_a + w_b + rbca_pkg::SEQ_W'(i_sub);

endmodule

/* dv/tb_reorder_buffer_cumulative_ack_core.sv */
`timescale 1ns / 1ps

module tb_reorder_buffer_cumulative_ack_core;

    localparam int SEQ_W         = rbca_pkg::SEQ_W;
    localparam int HANDLE_W      = rbca_pkg::HANDLE_W;
    localparam int LEN_W         = rbca_pkg::LEN_W;
    localparam int HALF_BIT      = rbca_pkg::HALF_BIT;

    localparam int SLOTS         = 16;
    localparam int PAYLOAD_CAP   = 5000;
    localparam int RANDOM_ITEMS  = 125;
    localparam int CALM_ITEMS    = 30;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        rbca_pkg::t_in_item  pkt;
        bit                  typed;
        rbca_pkg::t_out_item answer;
    } t_script_row;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    rbca_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    rbca_pkg::t_out_item out_item;

    // Receiver state as the scoreboard sees it
    logic [SEQ_W-1:0]    next_seq = 31'd1;
    logic                held_valid [SLOTS];
    logic [HANDLE_W-1:0] held_handle [SLOTS];
    logic [LEN_W-1:0]    held_length [SLOTS];
    int                  head_slot = 0;

    rbca_pkg::t_out_item release_run[$];
    rbca_pkg::t_out_item awaited_results[$];
    t_script_row         script[$];

    bit calm_tail;
    bit hold_off_req;
    bit hold_off_done;

    int mismatches;
    int cycle_count;
    int packets_sent;
    int fins_sent;
    int drops_seen;
    int results_checked;
    int longest_run;

    reorder_buffer_cumulative_ack_core #(
        .WINDOW_SLOTS (SLOTS),
        .MAX_PAYLOAD  (PAYLOAD_CAP)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Give up if the block stops making progress
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results still awaited",
                   cycle_count, awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic rbca_pkg::t_in_item data_pkt(logic [SEQ_W-1:0] seq,
                                                    logic [HANDLE_W-1:0] handle,
                                                    logic [LEN_W-1:0] len);
        rbca_pkg::t_in_item p;
        p.op             = rbca_pkg::OP_DATA;
        p.seq_num        = seq;
        p.payload_handle = handle;
        p.payload_length = len;
        return p;
    endfunction

    function automatic rbca_pkg::t_out_item acked(logic [SEQ_W-1:0] ack,
                                                  logic [SEQ_W-1:0] echo, logic drop);
        rbca_pkg::t_out_item r;
        r           = '0;
        r.ack_valid = 1'b1;
        r.ack_num   = ack;
        r.echo_seq  = echo;
        r.dropped   = drop;
        r.last      = 1'b1;
        return r;
    endfunction

    // Work out the results of one accepted packet and advance the receiver state.
    // The results land in release_run, oldest first.
    task automatic receive_packet(input rbca_pkg::t_in_item pkt);
        rbca_pkg::t_out_item r;
        logic [SEQ_W-1:0]    delta;
        logic [SEQ_W-1:0]    cur_seq;
        logic [HANDLE_W-1:0] cur_handle;
        logic [LEN_W-1:0]    cur_len;
        logic [LEN_W-1:0]    len;
        int                  idx;
        int                  n;
        bit                  done;

        release_run.delete();
        r = '0;
        if (pkt.op == rbca_pkg::OP_FIN) begin
            r.fin_ack = 1'b1;
            r.last    = 1'b1;
            release_run.push_back(r);
            return;
        end
        len   = (pkt.payload_length > PAYLOAD_CAP) ? LEN_W'(PAYLOAD_CAP) : pkt.payload_length;
        delta = pkt.seq_num - next_seq;

        if (delta == '0) begin
            // In order: release it, then drain consecutive buffered packets
            cur_seq    = pkt.seq_num;
            cur_handle = pkt.payload_handle;
            cur_len    = len;
            held_valid[head_slot] = 1'b0;
            n    = 0;
            done = 1'b0;
            while (!done) begin
                next_seq  = next_seq + 1'b1;
                head_slot = (head_slot + 1) % SLOTS;
                r = '0;
                r.deliver_valid  = 1'b1;
                r.deliver_seq    = cur_seq;
                r.deliver_handle = cur_handle;
                r.deliver_length = cur_len;
                if (!(held_valid[head_slot] && (n + 1) < SLOTS)) begin
                    r.ack_valid = 1'b1;
                    r.ack_num   = next_seq;
                    r.echo_seq  = pkt.seq_num;
                    r.last      = 1'b1;
                    done        = 1'b1;
                end else begin
                    cur_seq    = next_seq;
                    cur_handle = held_handle[head_slot];
                    cur_len    = held_length[head_slot];
                    held_valid[head_slot] = 1'b0;
                end
                release_run.push_back(r);
                n++;
            end
        end else begin
            if (delta < SLOTS) begin
                // Inside the window: buffer it, overwriting any earlier copy
                idx = (head_slot + int'(delta)) % SLOTS;
                held_valid[idx]  = 1'b1;
                held_handle[idx] = pkt.payload_handle;
                held_length[idx] = len;
                release_run.push_back(acked(next_seq, pkt.seq_num, 1'b0));
            end else begin
                // Beyond the window but in the forward half: drop and flag.
                // Backward half: plain re-acknowledge.
                release_run.push_back(acked(next_seq, pkt.seq_num, !delta[HALF_BIT]));
            end
        end
    endtask

    // Mostly well-formed traffic around the next expected number, with some noise
    function automatic rbca_pkg::t_in_item random_packet();
        rbca_pkg::t_in_item p;
        logic [SEQ_W-1:0]   delta;
        int                 pick;

        p = data_pkt('0, HANDLE_W'($urandom_range(0, 65535)), '0);
        if ($urandom_range(0, 6) == 0) begin
            p.payload_length = LEN_W'($urandom_range(PAYLOAD_CAP + 1, 8191));
        end else begin
            p.payload_length = LEN_W'($urandom_range(0, PAYLOAD_CAP));
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            p.op             = rbca_pkg::OP_FIN;
            p.seq_num        = SEQ_W'($urandom);
            p.payload_length = LEN_W'($urandom);
            return p;
        end else if (pick < 22) begin
            delta = '0;
        end else if (pick < 62) begin
            delta = SEQ_W'($urandom_range(1, $urandom_range(1, SLOTS - 1)));
        end else if (pick < 68) begin
            case ($urandom_range(0, 4))
                0:       delta = SEQ_W'(SLOTS - 1);
                1:       delta = SEQ_W'(SLOTS);
                2:       delta = 31'h3FFF_FFFF;
                3:       delta = 31'h4000_0000;
                default: delta = 31'h7FFF_FFFF;
            endcase
        end else if (pick < 76) begin
            delta = SEQ_W'($urandom_range(SLOTS, 32'h3FFF_FFFF));
        end else if (pick < 88) begin
            delta = '0 - SEQ_W'($urandom_range(1, 40));
        end else begin
            delta = SEQ_W'($urandom) - next_seq;
        end
        p.seq_num = next_seq + delta;
        return p;
    endfunction

    // Offer one packet, hold it until taken, then queue what it should produce
    task automatic offer_packet(input rbca_pkg::t_in_item pkt, input bit typed,
                                input rbca_pkg::t_out_item answer);
        int gap;

        gap = 0;
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= pkt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);

        receive_packet(pkt);
        if (typed) begin
            awaited_results.push_back(answer);
        end else begin
            foreach (release_run[i]) awaited_results.push_back(release_run[i]);
        end
        packets_sent++;
        if (pkt.op == rbca_pkg::OP_FIN) fins_sent++;
        if (release_run[0].dropped) drops_seen++;
        if (release_run.size() > longest_run) longest_run = release_run.size();
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [SEQ_W-1:0] exp_v,
                               input logic [SEQ_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, steady in the tail
    initial begin : receiver
        int stall_left;
        int run_left;

        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off_done = 1'b1;
            end else if (calm_tail) begin
                out_ready <= 1'b1;
            end else begin
                if (stall_left == 0 && run_left == 0) begin
                    if ($urandom_range(0, 2) == 0) begin
                        stall_left = $urandom_range(1, 18);
                    end else begin
                        run_left = $urandom_range(1, 60);
                    end
                end
                if (stall_left > 0) begin
                    out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    out_ready <= 1'b1;
                    run_left--;
                end
            end
        end
    end

    // Compare every result transaction with the oldest one awaited
    always @(posedge clk) begin : scoreboard
        rbca_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing awaited: %p", out_item);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                check_field("deliver_valid",  want.deliver_valid,  out_item.deliver_valid);
                check_field("deliver_seq",    want.deliver_seq,    out_item.deliver_seq);
                check_field("deliver_handle", want.deliver_handle, out_item.deliver_handle);
                check_field("deliver_length", want.deliver_length, out_item.deliver_length);
                check_field("ack_valid",      want.ack_valid,      out_item.ack_valid);
                check_field("ack_num",        want.ack_num,        out_item.ack_num);
                check_field("echo_seq",       want.echo_seq,       out_item.echo_seq);
                check_field("fin_ack",        want.fin_ack,        out_item.fin_ack);
                check_field("dropped",        want.dropped,        out_item.dropped);
                check_field("last",           want.last,           out_item.last);
            end
        end
    end

    initial begin : stimulus
        t_script_row         row;
        rbca_pkg::t_out_item fin_reply;
        int                  k;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        calm_tail    = 1'b0;
        hold_off_req = 1'b0;
        foreach (held_valid[i]) held_valid[i] = 1'b0;

        fin_reply         = '0;
        fin_reply.fin_ack = 1'b1;
        fin_reply.last    = 1'b1;

        // Directed part; expectation typed in where the state right after reset
        // makes it obvious, otherwise left to the scoreboard model.
        row.typed      = 1'b1;
        row.pkt        = data_pkt(31'h7FFF_FFFF, 16'hFFFF, 13'h1FFF);
        row.pkt.op     = rbca_pkg::OP_FIN;
        row.answer     = fin_reply;
        script.push_back(row);
        // old packets, the two numbers just behind the expected one
        row.pkt    = data_pkt(31'h0, 16'h0000, 13'd0);
        row.answer = acked(31'd1, 31'h0, 1'b0);
        script.push_back(row);
        row.pkt    = data_pkt(31'h7FFF_FFFF, 16'h8000, 13'd1);
        row.answer = acked(31'd1, 31'h7FFF_FFFF, 1'b0);
        script.push_back(row);
        // just past the window, and the far edge of the forward half
        row.pkt    = data_pkt(31'd17, 16'h0F0F, 13'd64);
        row.answer = acked(31'd1, 31'd17, 1'b1);
        script.push_back(row);
        row.pkt    = data_pkt(31'h4000_0000, 16'hF0F0, 13'd5000);
        row.answer = acked(31'd1, 31'h4000_0000, 1'b1);
        script.push_back(row);
        // first number of the backward half
        row.pkt    = data_pkt(31'h4000_0001, 16'h1111, 13'd2);
        row.answer = acked(31'd1, 31'h4000_0001, 1'b0);
        script.push_back(row);
        // far edge of the window, then an oversize payload held in the window
        row.pkt    = data_pkt(31'd16, 16'h1234, 13'd100);
        row.answer = acked(31'd1, 31'd16, 1'b0);
        script.push_back(row);
        row.pkt    = data_pkt(31'd3, 16'h0001, 13'h1FFF);
        row.answer = acked(31'd1, 31'd3, 1'b0);
        script.push_back(row);

        row.typed  = 1'b0;
        row.answer = '0;
        // in order with a gap behind it: release one packet only
        row.pkt = data_pkt(31'd1, 16'hFFFF, 13'd8191);
        script.push_back(row);
        // fill the window backwards but for number 2, overwriting 3 and 16 on the way
        for (k = 17; k >= 3; k--) begin
            row.pkt = data_pkt(SEQ_W'(k), HANDLE_W'(k * 16'h0111), LEN_W'(k * 311));
            script.push_back(row);
        end
        // close the hole: the longest possible release run
        row.pkt = data_pkt(31'd2, 16'hAAAA, 13'd0);
        script.push_back(row);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i]) offer_packet(script[i].pkt, script[i].typed, script[i].answer);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 20) hold_off_req = 1'b1;
            if (k == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
            offer_packet(random_packet(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d packets: %0d close requests, %0d dropped beyond the window",
                 packets_sent, fins_sent, drops_seen);
        $display("Checked %0d results; longest in-order release run %0d packets",
                 results_checked, longest_run);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
